[sv/rcfd_pkg.sv]
`default_nettype none

package rcfd_pkg;

   // frame layout
   localparam int PAY_BYTES   = 22;
   localparam int PAY_BITS    = PAY_BYTES * 8;
   localparam int RC_TOTAL    = 26;
   localparam int POS_TYPE    = 2;
   localparam int POS_PAYLOAD = 3;
   localparam int MIN_LEN     = 2;

   // compare width for positions and totals (total never exceeds 257)
   localparam int CMP_W = 10;

   // channel unpacking
   localparam int CH_W  = 11;
   localparam int IDX_W = 4;

   // crc
   localparam logic [7:0] CRC_POLY = 8'hD5;
   localparam logic [7:0] CRC_MSB  = 8'h80;

   // configuration register indexes
   localparam logic CSR_SYNC_BYTE = 1'b0;
   localparam logic CSR_RC_TYPE   = 1'b1;

   typedef enum logic [1:0] {
      STATUS_CHANNEL = 2'd0,
      STATUS_CRC_BAD = 2'd1,
      STATUS_NOT_RC  = 2'd2
   } status_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_CHAN = 1'b1
   } back_state_type;

   // one completed frame handed from front to back
   typedef struct packed {
      status_type status;
      logic [7:0] frame_type;
      logic [6:0] frame_length;
   } job_type;

endpackage

`default_nettype wire

[sv/rcfd_front.sv]
`default_nettype none

module rcfd_front import rcfd_pkg::*; #(
   parameter int MAX_FRAME = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_rx_byte,
   input  wire logic [7:0]          sync_byte,
   input  wire logic [7:0]          rc_type,
   input  wire logic                chan_pending,
   input  wire logic                q_full,
   output logic                     push,
   output job_type                  push_job,
   output logic [PAY_BITS-1:0]      payload
);

   localparam int POS_W = $clog2(MAX_FRAME);
   localparam logic [CMP_W-1:0] MAX_TOTAL = CMP_W'(MAX_FRAME);

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [7:0]          len_ff, len_in;
   logic [7:0]          type_ff, type_in;
   logic [7:0]          crc_ff, crc_in;
   logic [PAY_BITS-1:0] payload_ff, payload_in;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] total;
   logic             more;
   logic             hunting;
   logic             at_len;
   logic             is_data;
   logic             is_final;
   logic             is_store;
   logic             len_bad;
   logic             accept;
   logic [7:0]       crc_next;

   // crc-8, msb first, one byte
   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 8'd0) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   // position decode from registered state only
   always_comb begin
      pos_ext  = CMP_W'(pos_ff);
      total    = CMP_W'(len_ff) + CMP_W'(MIN_LEN);
      more     = (pos_ext + CMP_W'(1)) < total;
      hunting  = (pos_ext == CMP_W'(0));
      at_len   = (pos_ext == CMP_W'(1));
      is_data  = (pos_ext >= CMP_W'(POS_TYPE)) && more;
      is_final = (pos_ext >= CMP_W'(POS_TYPE)) && !more;
      is_store = is_data && (pos_ext >= CMP_W'(POS_PAYLOAD))
                 && (pos_ext < CMP_W'(POS_PAYLOAD + PAY_BYTES));
   end

   // hold payload writes while a channel frame still waits for the back part, and the crc byte while the queue is full
   assign req_stall = (is_store && chan_pending) || (is_final && q_full);
   assign accept    = req_valid && !req_stall;

   assign len_bad  = (req_rx_byte < 8'(MIN_LEN))
                     || ((CMP_W'(req_rx_byte) + CMP_W'(MIN_LEN)) > MAX_TOTAL);
   assign crc_next = crc_update(crc_ff, req_rx_byte);

   // frame tracking
   always_comb begin
      pos_in     = pos_ff;
      len_in     = len_ff;
      type_in    = type_ff;
      crc_in     = crc_ff;
      payload_in = payload_ff;
      push       = 1'b0;
      push_job.frame_type   = type_ff;
      push_job.frame_length = total[6:0];
      if ((total != CMP_W'(RC_TOTAL)) || (type_ff != rc_type)) begin
         push_job.status = STATUS_NOT_RC;
      end else if (crc_ff != req_rx_byte) begin
         push_job.status = STATUS_CRC_BAD;
      end else begin
         push_job.status = STATUS_CHANNEL;
      end
      if (accept) begin
         if (hunting) begin
            if (req_rx_byte == sync_byte) begin
               pos_in = POS_W'(1);
            end
         end else if (at_len) begin
            if (len_bad) begin
               pos_in = (req_rx_byte == sync_byte) ? POS_W'(1) : POS_W'(0);
            end else begin
               len_in = req_rx_byte;
               crc_in = 8'd0;
               pos_in = POS_W'(POS_TYPE);
            end
         end else if (is_data) begin
            if (pos_ext == CMP_W'(POS_TYPE)) begin
               type_in = req_rx_byte;
            end
            if (is_store) begin
               payload_in = {req_rx_byte, payload_ff[PAY_BITS-1:8]};
            end
            crc_in = crc_next;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            pos_in = POS_W'(0);
            push   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         len_ff  <= '0;
         type_ff <= '0;
         crc_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         type_ff <= type_in;
         crc_ff  <= crc_in;
      end
   end

   // payload shift line, first byte ends at the bottom
   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   assign payload = payload_ff;

endmodule

`default_nettype wire

[sv/rcfd_queue.sv]
`default_nettype none

module rcfd_queue import rcfd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         empty,
   output logic         full,
   output job_type      head,
   output logic         chan_pending
);

   job_type    entry_ff [2];
   job_type    entry_in [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);
   assign head  = entry_ff[rd_ff];

   // a channel frame is queued and not yet loaded by the back part
   assign chan_pending =
      ((count_ff != 2'd0) && (entry_ff[rd_ff].status == STATUS_CHANNEL))
      || ((count_ff == 2'd2) && (entry_ff[!rd_ff].status == STATUS_CHANNEL));

   // pointer and count update
   always_comb begin
      entry_in[0] = entry_ff[0];
      entry_in[1] = entry_ff[1];
      wr_in       = wr_ff;
      rd_in       = rd_ff;
      count_in    = count_ff;
      if (push) begin
         entry_in[wr_ff] = push_job;
         wr_in           = !wr_ff;
      end
      if (pop) begin
         rd_in = !rd_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff[0] <= entry_in[0];
      entry_ff[1] <= entry_in[1];
   end

endmodule

`default_nettype wire

[sv/rcfd_back.sv]
`default_nettype none

module rcfd_back import rcfd_pkg::*; #(
   parameter int NUM_CHANNELS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire job_type             head,
   output logic                     pop,
   input  wire logic [PAY_BITS-1:0] payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [IDX_W-1:0]         rsp_channel_index,
   output logic [CH_W-1:0]          rsp_channel_value,
   output logic [7:0]               rsp_frame_type,
   output logic [6:0]               rsp_frame_length,
   output logic                     rsp_last
);

   localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(NUM_CHANNELS - 1);

   back_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   job_type             job_ff, job_in;
   logic [PAY_BITS-1:0] unpack_ff, unpack_in;

   logic             valid_ff, valid_in;
   status_type       status_ff, status_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [CH_W-1:0]  value_ff, value_in;
   logic [7:0]       ftype_ff, ftype_in;
   logic [6:0]       flen_ff, flen_in;
   logic             last_ff, last_in;

   logic can_load;
   logic emit_status;
   logic start_chan;
   logic emit_chan;

   assign can_load = !valid_ff || !rsp_stall;

   // control outputs
   always_comb begin
      pop         = (state_ff == BK_IDLE) && !q_empty && can_load;
      emit_status = pop && (head.status != STATUS_CHANNEL);
      start_chan  = pop && (head.status == STATUS_CHANNEL);
      emit_chan   = (state_ff == BK_CHAN) && can_load;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start_chan) begin
               state_in = BK_CHAN;
            end
         end
         BK_CHAN: begin
            if (emit_chan && (cnt_ff == LAST_CH)) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // unpack shift line and output word register
   always_comb begin
      cnt_in    = cnt_ff;
      job_in    = job_ff;
      unpack_in = unpack_ff;
      valid_in  = can_load ? 1'b0 : valid_ff;
      status_in = status_ff;
      index_in  = index_ff;
      value_in  = value_ff;
      ftype_in  = ftype_ff;
      flen_in   = flen_ff;
      last_in   = last_ff;
      if (start_chan) begin
         job_in    = head;
         unpack_in = payload;
         cnt_in    = '0;
      end
      if (emit_status) begin
         valid_in  = 1'b1;
         status_in = head.status;
         index_in  = '0;
         value_in  = '0;
         ftype_in  = head.frame_type;
         flen_in   = head.frame_length;
         last_in   = 1'b1;
      end
      if (emit_chan) begin
         valid_in  = 1'b1;
         status_in = STATUS_CHANNEL;
         index_in  = cnt_ff;
         value_in  = unpack_ff[CH_W-1:0];
         ftype_in  = job_ff.frame_type;
         flen_in   = job_ff.frame_length;
         last_in   = (cnt_ff == LAST_CH);
         unpack_in = {CH_W'(0), unpack_ff[PAY_BITS-1:CH_W]};
         cnt_in    = cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      unpack_ff <= unpack_in;
      status_ff <= status_in;
      index_ff  <= index_in;
      value_ff  <= value_in;
      ftype_ff  <= ftype_in;
      flen_ff   <= flen_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_channel_index = index_ff;
   assign rsp_channel_value = value_ff;
   assign rsp_frame_type    = ftype_ff;
   assign rsp_frame_length  = flen_ff;
   assign rsp_last          = last_ff;

endmodule

`default_nettype wire

[sv/rc_frame_deframer_channel_unpack_unit.sv]
// channel   direction  words                       handshake
// req       in         req_rx_byte                 req_valid / req_stall
// rsp       out        status, channel, frame info rsp_valid / rsp_stall
// csr       in         sync byte, rc frame type    csr_write_enable
//
// the front takes one byte per cycle unless req_stall holds it; a completed frame goes into a two-entry queue.
// the back sends a status word as it pops the frame; for a channel frame it first pops the frame
// to load the payload shift line, then sends one 11-bit channel word per cycle unless rsp_stall holds a word.
// payload bytes of the next frame stall while a channel frame waits in the queue.
// the crc byte of a frame stalls while the queue is full.
// reset is synchronous and clears control state; registers return to 200 and 22.
`default_nettype none

module rc_frame_deframer_channel_unpack_unit import rcfd_pkg::*; #(
   parameter int MAX_FRAME    = 64,
   parameter int NUM_CHANNELS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [IDX_W-1:0]      rsp_channel_index,
   output logic [CH_W-1:0]       rsp_channel_value,
   output logic [7:0]            rsp_frame_type,
   output logic [6:0]            rsp_frame_length,
   output logic                  rsp_last,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_index,
   input  wire logic [7:0]       csr_write_data
);

   logic [7:0] sync_ff, sync_in;
   logic [7:0] rctype_ff, rctype_in;

   logic                push;
   job_type             push_job;
   logic                pop;
   logic                q_empty;
   logic                q_full;
   job_type             head;
   logic                chan_pending;
   logic [PAY_BITS-1:0] payload;

   // configuration registers
   always_comb begin
      sync_in   = sync_ff;
      rctype_in = rctype_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SYNC_BYTE: sync_in   = csr_write_data;
            CSR_RC_TYPE:   rctype_in = csr_write_data;
            default:       sync_in   = sync_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff   <= 8'd200;
         rctype_ff <= 8'd22;
      end else begin
         sync_ff   <= sync_in;
         rctype_ff <= rctype_in;
      end
   end

   rcfd_front #(
      .MAX_FRAME(MAX_FRAME)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .sync_byte    (sync_ff),
      .rc_type      (rctype_ff),
      .chan_pending (chan_pending),
      .q_full       (q_full),
      .push         (push),
      .push_job     (push_job),
      .payload      (payload)
   );

   rcfd_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_job     (push_job),
      .pop          (pop),
      .empty        (q_empty),
      .full         (q_full),
      .head         (head),
      .chan_pending (chan_pending)
   );

   rcfd_back #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .head              (head),
      .pop               (pop),
      .payload           (payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

[sv/rcfd_checker.sv]
`default_nettype none

module rcfd_checker import rcfd_pkg::*; #(
   parameter int NUM_CHANNELS = 16
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [1:0]       rsp_status,
   input wire logic [IDX_W-1:0] rsp_channel_index,
   input wire logic [CH_W-1:0]  rsp_channel_value,
   input wire logic [7:0]       rsp_frame_type,
   input wire logic [6:0]       rsp_frame_length,
   input wire logic             rsp_last
);

   // no word shows right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_channel_index) && $stable(rsp_channel_value)
         && $stable(rsp_frame_type) && $stable(rsp_frame_length) && $stable(rsp_last))
      else $error("stalled result word changed");

   // status words close their frame and carry no channel
   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_CHANNEL) |->
         rsp_last && (rsp_channel_index == '0) && (rsp_channel_value == '0)
         && ((rsp_status == STATUS_CRC_BAD) || (rsp_status == STATUS_NOT_RC)))
      else $error("malformed status word");

   // channel words come only from full rc frames and end on the last channel
   a_chan_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_CHANNEL) |->
         (rsp_frame_length == 7'(RC_TOTAL))
         && (rsp_last == (rsp_channel_index == IDX_W'(NUM_CHANNELS - 1))))
      else $error("malformed channel word");

endmodule

bind rc_frame_deframer_channel_unpack_unit rcfd_checker #(
   .NUM_CHANNELS(NUM_CHANNELS)
) u_rcfd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_channel_index (rsp_channel_index),
   .rsp_channel_value (rsp_channel_value),
   .rsp_frame_type    (rsp_frame_type),
   .rsp_frame_length  (rsp_frame_length),
   .rsp_last          (rsp_last)
);

`default_nettype wire

[verif/tb_rc_frame_deframer_channel_unpack_unit.sv]
`timescale 1ns / 1ps

module tb_rc_frame_deframer_channel_unpack_unit;
   import rcfd_pkg::*;

   localparam int MAX_FRAME    = 64;
   localparam int NUM_CHANNELS = 16;
   localparam int RC_LEN       = RC_TOTAL - 2;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 500000;

   // one expected result word
   typedef struct {
      status_type       status;
      logic [IDX_W-1:0] chan;
      logic [CH_W-1:0]  val;
      logic [7:0]       ftype;
      logic [6:0]       flen;
      logic             last;
   } rc_word_type;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic             req_stall;
   logic [7:0]       req_rx_byte      = 8'h00;
   logic             rsp_valid;
   logic             rsp_stall        = 1'b0;
   logic [1:0]       rsp_status;
   logic [IDX_W-1:0] rsp_channel_index;
   logic [CH_W-1:0]  rsp_channel_value;
   logic [7:0]       rsp_frame_type;
   logic [6:0]       rsp_frame_length;
   logic             rsp_last;
   logic             csr_write_enable = 1'b0;
   logic             csr_index        = 1'b0;
   logic [7:0]       csr_write_data   = 8'h00;

   // stimulus and expectations
   logic [7:0]  rx_bytes_q[$];
   rc_word_type expected_words_q[$];
   int          bytes_queued   = 0;
   int          error_count    = 0;
   int          cycle_count    = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;

   // deframer state as the testbench sees it
   logic [7:0]          sync_reg     = 8'd200;
   logic [7:0]          rc_type_reg  = 8'd22;
   logic [6:0]          frame_pos    = '0;
   logic [7:0]          declared_len = '0;
   logic [7:0]          type_seen    = '0;
   logic [7:0]          crc_run      = '0;
   logic [PAY_BITS-1:0] payload_bits = '0;

   rc_frame_deframer_channel_unpack_unit #(
      .MAX_FRAME   (MAX_FRAME),
      .NUM_CHANNELS(NUM_CHANNELS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_channel_index(rsp_channel_index),
      .rsp_channel_value(rsp_channel_value),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // crc-8, poly 0xd5, msb first
   function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // advance the deframer by one byte and queue the words it produces
   task automatic deframe_byte(input logic [7:0] b);
      rc_word_type w;
      int          total;
      int          pidx;
      total = int'(declared_len) + 2;
      if (frame_pos == 0) begin
         if (b == sync_reg) frame_pos = 7'd1;
      end else if (frame_pos == 1) begin
         if (int'(b) < MIN_LEN || int'(b) + 2 > MAX_FRAME) begin
            frame_pos = (b == sync_reg) ? 7'd1 : 7'd0;
         end else begin
            declared_len = b;
            crc_run      = '0;
            frame_pos    = 7'd2;
         end
      end else if (int'(frame_pos) + 1 < total) begin
         // type or payload byte
         pidx = int'(frame_pos) - POS_PAYLOAD;
         if (frame_pos == POS_TYPE) type_seen = b;
         else if (pidx < PAY_BYTES) payload_bits[pidx*8 +: 8] = b;
         crc_run   = crc8_d5(crc_run, b);
         frame_pos = frame_pos + 7'd1;
      end else begin
         // crc byte closes the frame
         frame_pos = '0;
         w.chan    = '0;
         w.val     = '0;
         w.ftype   = type_seen;
         w.flen    = 7'(total);
         w.last    = 1'b1;
         if (total != RC_TOTAL || type_seen != rc_type_reg) begin
            w.status = STATUS_NOT_RC;
            expected_words_q.push_back(w);
         end else if (crc_run != b) begin
            w.status = STATUS_CRC_BAD;
            expected_words_q.push_back(w);
         end else begin
            for (int n = 0; n < NUM_CHANNELS; n++) begin
               w.status = STATUS_CHANNEL;
               w.chan   = IDX_W'(n);
               w.val    = payload_bits[n*CH_W +: CH_W];
               w.last   = (n == NUM_CHANNELS - 1);
               expected_words_q.push_back(w);
            end
         end
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      rx_bytes_q.push_back(b);
      bytes_queued++;
   endtask

   // whole frame; fill < 0 gives random payload, else a constant byte
   task automatic queue_frame(input int len, input logic [7:0] typ, input bit crc_ok,
                              input int fill);
      logic [7:0] crc;
      logic [7:0] p;
      crc = crc8_d5(8'h00, typ);
      push_byte(sync_reg);
      push_byte(8'(len));
      push_byte(typ);
      for (int i = 0; i < len - 2; i++) begin
         p = (fill < 0) ? 8'($urandom) : 8'(fill);
         push_byte(p);
         crc = crc8_d5(crc, p);
      end
      push_byte(crc_ok ? crc : crc ^ 8'($urandom_range(1, 255)));
   endtask

   // mostly well-formed frames, the rest noise and broken frames
   task automatic random_traffic(input int nbytes);
      int         start;
      int         pick;
      logic [7:0] b;
      start = bytes_queued;
      while (bytes_queued - start < nbytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            queue_frame(RC_LEN, rc_type_reg, 1'b1, -1);
         end else if (pick < 50) begin
            queue_frame(RC_LEN, rc_type_reg, 1'b0, -1);
         end else if (pick < 60) begin
            queue_frame(RC_LEN, rc_type_reg ^ 8'($urandom_range(1, 255)),
                        1'($urandom_range(0, 1)), -1);
         end else if (pick < 75) begin
            queue_frame($urandom_range(MIN_LEN, 10), 8'($urandom),
                        1'($urandom_range(0, 1)), -1);
         end else if (pick < 80) begin
            // long frame, payload past the stored part
            queue_frame($urandom_range(0, 1) ? MAX_FRAME - 2 : $urandom_range(RC_LEN + 1, 61),
                        rc_type_reg, 1'b1, -1);
         end else if (pick < 88) begin
            // bad length byte
            push_byte(sync_reg);
            push_byte($urandom_range(0, 2) == 0 ? 8'($urandom_range(0, MIN_LEN - 1))
                                                : 8'($urandom_range(MAX_FRAME - 1, 255)));
         end else if (pick < 93) begin
            // doubled sync ahead of a good frame
            push_byte(sync_reg);
            queue_frame(RC_LEN, rc_type_reg, 1'b1, -1);
         end else if (pick < 97) begin
            // line noise while hunting
            repeat ($urandom_range(1, 4)) begin
               b = 8'($urandom);
               if (b != sync_reg) push_byte(b);
            end
         end else begin
            // frame cut short
            push_byte(sync_reg);
            push_byte(8'($urandom_range(MIN_LEN, MAX_FRAME - 2)));
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
         end
      end
   endtask

   // all words sent and returned, then let the back end settle
   task automatic wait_idle();
      while (rx_bytes_q.size() != 0 || req_valid || expected_words_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_SYNC_BYTE) sync_reg = data;
      else rc_type_reg = data;
   endtask

   task automatic run_phase(input logic [7:0] sync_val, input logic [7:0] type_val,
                            input int send_pct, input int stall_pct, input int nbytes);
      wait_idle();
      write_csr(CSR_SYNC_BYTE, sync_val);
      write_csr(CSR_RC_TYPE, type_val);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      random_traffic(nbytes);
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) deframe_byte(req_rx_byte);
         if (!req_valid || !req_stall) begin
            if (rx_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_bytes_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_monitor
      rc_word_type exp_w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words_q.size() == 0) begin
               $error("unexpected word: status %0d channel %0d value %0d",
                      rsp_status, rsp_channel_index, rsp_channel_value);
               error_count++;
            end else begin
               exp_w = expected_words_q.pop_front();
               if (rsp_status != exp_w.status) begin
                  $error("status: expected %0d, got %0d", exp_w.status, rsp_status);
                  error_count++;
               end
               if (rsp_channel_index != exp_w.chan) begin
                  $error("channel_index: expected %0d, got %0d", exp_w.chan,
                         rsp_channel_index);
                  error_count++;
               end
               if (rsp_channel_value != exp_w.val) begin
                  $error("channel_value: expected %0d, got %0d", exp_w.val,
                         rsp_channel_value);
                  error_count++;
               end
               if (rsp_frame_type != exp_w.ftype) begin
                  $error("frame_type: expected %0d, got %0d", exp_w.ftype, rsp_frame_type);
                  error_count++;
               end
               if (rsp_frame_length != exp_w.flen) begin
                  $error("frame_length: expected %0d, got %0d", exp_w.flen,
                         rsp_frame_length);
                  error_count++;
               end
               if (rsp_last != exp_w.last) begin
                  $error("last: expected %0d, got %0d", exp_w.last, rsp_last);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset register values, no idling
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(sync_reg);
      push_byte(8'd0);
      push_byte(sync_reg);
      push_byte(8'd1);
      push_byte(sync_reg);
      push_byte(8'(MAX_FRAME - 1));
      // bad length that matches sync restarts the frame, then shortest frame
      push_byte(sync_reg);
      push_byte(sync_reg);
      queue_frame(MIN_LEN, 8'hFF, 1'b1, -1);
      // all-ones channels
      queue_frame(RC_LEN, rc_type_reg, 1'b1, 8'hFF);
      random_traffic(50);

      run_phase(8'h00, 8'h00, 67, 0, 100);
      run_phase(8'hFF, 8'hFF, 0, 67, 100);
      run_phase(8'($urandom), 8'($urandom), 14, 14, 100);
      run_phase(8'd24, 8'd200, 0, 0, 100);

      wait_idle();
      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
